FILE: src/bta_pkg.sv
// Shared types and constants for the block table allocator.
package bta_pkg;

    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int BLOCK_BYTES    = 256;
    // Block size is a power of two: byte-to-block rounding is a shift and a mask.
    localparam int BLOCK_SHIFT    = $clog2(BLOCK_BYTES);

    localparam int SIZE_W   = 19;
    localparam int CNT_W    = 11;
    localparam int BLK_W    = 10;
    localparam int CNT_MAX  = (1 << CNT_W) - 1;
    localparam int NEED_W   = SIZE_W - BLOCK_SHIFT + 1;
    localparam int ACTIVE_RESET = 1024;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESIZE = 2'd2;

    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_NOSPACE      = 2'd1;
    localparam logic [1:0] STAT_RELEASED     = 2'd2;
    localparam logic [1:0] STAT_ALREADY_FREE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_SCAN,
        ST_FILL,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic clr_start;
    } tbl_ctl_t;

endpackage

FILE: src/bta_table.sv
// Chain table memory with registered read and a clearing sweep.
module bta_table import bta_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tbl_ctl_t                      ctl,
    input  logic [$clog2(NUM_BLOCKS)-1:0] wr_addr,
    input  logic [CNT_W-1:0]              wr_data,
    input  logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
    output logic [CNT_W-1:0]              rd_data,
    output logic                          clr_busy
);

    localparam int AW = $clog2(NUM_BLOCKS);

    logic [CNT_W-1:0] chain_mem [NUM_BLOCKS];
    logic [CNT_W-1:0] rd_data_reg;
    logic             clr_busy_reg, clr_busy_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;

    // Sweep owns the write port while it runs.
    always_comb begin
        mem_we    = clr_busy_reg || ctl.wr_en;
        mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_busy_reg ? '0 : wr_data;
    end

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (ctl.clr_start) begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == AW'(NUM_BLOCKS - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            chain_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= chain_mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

FILE: src/block_table_allocator.sv
// First-fit contiguous block allocator over a chain table, one command per word.
// Steps per command: take the word, read the head entry and decode; first-fit scan; fill the
//   run; walk an old chain; post the result. A grow scans, fills the new run, then walks and
//   releases its old chain.
// Throughput: one command at a time; s_ready stays low until the result has been posted.
// Reset and every active_blocks write start a sweep that zeroes the table.
module block_table_allocator import bta_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration: active_blocks
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    // command channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  logic [SIZE_W-1:0] s_size_bytes,
    input  logic              s_has_block,
    input  logic [BLK_W-1:0]  s_block_number,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [BLK_W-1:0]  m_first_block,
    output logic              m_copy_needed,
    output logic [BLK_W-1:0]  m_copy_source,
    output logic [CNT_W-1:0]  m_copy_blocks,
    output logic [CNT_W-1:0]  m_free_blocks
);

    localparam int AW        = $clog2(NUM_BLOCKS);
    localparam int NB_CAP    = (NUM_BLOCKS < CNT_MAX) ? NUM_BLOCKS : CNT_MAX;
    localparam int RESET_EFF = (ACTIVE_RESET < NUM_BLOCKS) ? ACTIVE_RESET : NUM_BLOCKS;

    // sequencer and configuration
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic [CNT_W-1:0]  free_reg, free_next;

    // latched command word
    logic [1:0]        cmd_reg, cmd_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic              size_zero_reg, size_zero_next;
    logic              has_reg, has_next;
    logic [CNT_W-1:0]  blk_reg, blk_next;

    // scan / fill / walk datapath
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  chk_pos_reg, chk_pos_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]  kiss_reg, kiss_next;
    logic [CNT_W-1:0]  chk_k_reg, chk_k_next;
    logic [CNT_W-1:0]  old_reg, old_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;
    logic [CNT_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic              grow_reg, grow_next;

    // pending result
    logic [1:0]        res_status_reg, res_status_next;
    logic [CNT_W-1:0]  res_first_reg, res_first_next;
    logic              res_copy_reg, res_copy_next;
    logic [CNT_W-1:0]  res_csrc_reg, res_csrc_next;
    logic [CNT_W-1:0]  res_cblk_reg, res_cblk_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [BLK_W-1:0]  m_first_reg, m_first_next;
    logic              m_copy_reg, m_copy_next;
    logic [BLK_W-1:0]  m_csrc_reg, m_csrc_next;
    logic [CNT_W-1:0]  m_cblk_reg, m_cblk_next;
    logic [CNT_W-1:0]  m_free_reg, m_free_next;

    // table port
    tbl_ctl_t          tbl_ctl;
    logic [AW-1:0]     tbl_waddr;
    logic [CNT_W-1:0]  tbl_wdata;
    logic [CNT_W-1:0]  rd_data;
    logic              clr_busy;

    // helpers
    logic [CNT_W-1:0]  eff_cnt;
    logic [CNT_W-1:0]  cfg_eff;
    logic [NEED_W-1:0] s_need;
    logic [CNT_W-1:0]  entry_val;
    logic [CNT_W-1:0]  old_val;
    logic [CNT_W-1:0]  run_eval;
    logic [CNT_W-1:0]  run_start;
    logic              in_accept;
    logic              scan_found;
    logic              scan_issue;
    logic              walk_stop;
    logic              walk_issue;
    logic              walk_keep;
    logic              fill_last;
    logic              out_load;
    state_t            dec_state;
    logic [1:0]        dec_status;
    logic              dec_first_blk;
    logic              dec_grow;
    logic [CNT_W-1:0]  dec_keep;

    bta_table #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (tbl_ctl),
        .wr_addr  (tbl_waddr),
        .wr_data  (tbl_wdata),
        .rd_addr  (AW'(pos_reg)),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    // Hold off new words while idle-only work (sweep, config write) is going on.
    assign s_ready   = (state_reg == ST_IDLE) && !clr_busy && !cfg_wr_en;
    assign in_accept = s_valid && s_ready;

    // Shared conditions for the sequencer and the datapath.
    always_comb begin
        // Clamp active_blocks to the table depth.
        eff_cnt = (32'(active_reg) > NB_CAP) ? CNT_W'(NB_CAP) : active_reg;
        cfg_eff = (32'(cfg_wr_data) > NB_CAP) ? CNT_W'(NB_CAP) : cfg_wr_data;

        // Round bytes up to whole blocks.
        s_need = NEED_W'(s_size_bytes >> BLOCK_SHIFT)
               + NEED_W'(|(s_size_bytes & SIZE_W'(BLOCK_BYTES - 1)));

        // A block number beyond the active range reads as free.
        entry_val = (blk_reg < eff_cnt) ? rd_data : '0;
        old_val   = (cmd_reg == CMD_RESIZE && !has_reg) ? '0 : entry_val;

        run_eval   = (rd_data == '0) ? run_reg + 1'b1 : '0;
        scan_found = chk_vld_reg && (NEED_W'(run_eval) == need_reg);
        scan_issue = pos_reg < eff_cnt;
        run_start  = chk_pos_reg - CNT_W'(need_reg) + 1'b1;

        walk_stop  = chk_vld_reg && (rd_data == '0);
        walk_issue = (pos_reg < eff_cnt) && (kiss_reg < old_reg);
        walk_keep  = chk_k_reg < keep_reg;

        fill_last  = val_reg == CNT_W'(1);
        out_load   = !m_valid_reg || m_ready;
    end

    // Pick the path for the latched command once the head entry is in.
    always_comb begin
        dec_state     = ST_DONE;
        dec_status    = STAT_NOSPACE;
        dec_first_blk = 1'b0;
        dec_grow      = 1'b0;
        dec_keep      = '0;
        unique case (cmd_reg)
            CMD_ALLOC: begin
                if (need_reg != '0) begin
                    dec_state = ST_SCAN;
                end
            end
            CMD_FREE: begin
                if (old_val == '0) begin
                    dec_status = STAT_ALREADY_FREE;
                end else begin
                    dec_status = STAT_OK;
                    dec_state  = ST_WALK;
                end
            end
            CMD_RESIZE: begin
                if (old_val == '0) begin
                    // null or free block: plain allocation
                    if (need_reg != '0) begin
                        dec_state = ST_SCAN;
                    end
                end else if (size_zero_reg) begin
                    dec_status = STAT_RELEASED;
                    dec_state  = ST_WALK;
                end else if (NEED_W'(old_val) > need_reg) begin
                    // shrink in place
                    dec_status    = STAT_OK;
                    dec_first_blk = 1'b1;
                    dec_keep      = CNT_W'(need_reg);
                    dec_state     = ST_WALK;
                end else if (NEED_W'(old_val) == need_reg) begin
                    dec_status    = STAT_OK;
                    dec_first_blk = 1'b1;
                end else begin
                    // grow: place a new run, then release the old chain
                    dec_grow  = 1'b1;
                    dec_state = ST_SCAN;
                end
            end
            default: begin
                dec_state = ST_DONE;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = dec_state;
            end
            ST_SCAN: begin
                if (scan_found) begin
                    state_next = ST_FILL;
                end else if (!scan_issue && !chk_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL: begin
                if (fill_last) begin
                    state_next = grow_reg ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (walk_stop) begin
                    state_next = ST_DONE;
                end else if (!walk_issue && !chk_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, table port and result.
    always_comb begin
        active_next     = active_reg;
        free_next       = free_reg;
        cmd_next        = cmd_reg;
        need_next       = need_reg;
        size_zero_next  = size_zero_reg;
        has_next        = has_reg;
        blk_next        = blk_reg;
        pos_next        = pos_reg;
        chk_pos_next    = chk_pos_reg;
        chk_vld_next    = chk_vld_reg;
        kiss_next       = kiss_reg;
        chk_k_next      = chk_k_reg;
        old_next        = old_reg;
        keep_next       = keep_reg;
        val_next        = val_reg;
        run_next        = run_reg;
        grow_next       = grow_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_copy_next   = res_copy_reg;
        res_csrc_next   = res_csrc_reg;
        res_cblk_next   = res_cblk_reg;
        m_status_next   = m_status_reg;
        m_first_next    = m_first_reg;
        m_copy_next     = m_copy_reg;
        m_csrc_next     = m_csrc_reg;
        m_cblk_next     = m_cblk_reg;
        m_free_next     = m_free_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        tbl_ctl.wr_en     = 1'b0;
        tbl_ctl.clr_start = cfg_wr_en;
        tbl_waddr         = AW'(chk_pos_reg);
        tbl_wdata         = '0;

        // A config write re-initializes the table and the free count.
        if (cfg_wr_en) begin
            active_next = cfg_wr_data;
            free_next   = cfg_eff;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    cmd_next        = s_cmd;
                    need_next       = s_need;
                    size_zero_next  = s_size_bytes == '0;
                    has_next        = s_has_block;
                    blk_next        = CNT_W'(s_block_number);
                    pos_next        = CNT_W'(s_block_number);
                    grow_next       = 1'b0;
                    res_status_next = STAT_NOSPACE;
                    res_first_next  = '0;
                    res_copy_next   = 1'b0;
                    res_csrc_next   = '0;
                    res_cblk_next   = '0;
                end
            end
            ST_LOOK: begin
                // head entry read in flight
            end
            ST_DECIDE: begin
                res_status_next = dec_status;
                if (dec_first_blk) begin
                    res_first_next = blk_reg;
                end
                grow_next    = dec_grow;
                old_next     = old_val;
                keep_next    = dec_keep;
                run_next     = '0;
                kiss_next    = '0;
                chk_vld_next = 1'b0;
                pos_next     = (dec_state == ST_SCAN) ? '0 : blk_reg;
            end
            ST_SCAN: begin
                // Issue one read a cycle, judge the entry read the cycle before.
                if (chk_vld_reg) begin
                    run_next = run_eval;
                end
                if (scan_found) begin
                    pos_next        = run_start;
                    val_next        = CNT_W'(need_reg);
                    chk_vld_next    = 1'b0;
                    res_status_next = STAT_OK;
                    res_first_next  = run_start;
                    if (grow_reg) begin
                        res_copy_next = 1'b1;
                        res_csrc_next = blk_reg;
                        res_cblk_next = old_reg;
                    end
                end else if (scan_issue) begin
                    pos_next     = pos_reg + 1'b1;
                    chk_pos_next = pos_reg;
                    chk_vld_next = 1'b1;
                end else begin
                    chk_vld_next = 1'b0;
                end
            end
            ST_FILL: begin
                // Write need, need-1, ..., 1 across the run.
                tbl_ctl.wr_en = 1'b1;
                tbl_waddr     = AW'(pos_reg);
                tbl_wdata     = val_reg;
                free_next     = free_reg - 1'b1;
                if (fill_last) begin
                    // set up the release of the old chain after a grow
                    pos_next     = blk_reg;
                    kiss_next    = '0;
                    keep_next    = '0;
                    chk_vld_next = 1'b0;
                end else begin
                    pos_next = pos_reg + 1'b1;
                    val_next = val_reg - 1'b1;
                end
            end
            ST_WALK: begin
                // Rewrite or clear each chain entry; stop at the first free one.
                if (chk_vld_reg && !walk_stop) begin
                    tbl_ctl.wr_en = 1'b1;
                    tbl_waddr     = AW'(chk_pos_reg);
                    if (walk_keep) begin
                        tbl_wdata = keep_reg - chk_k_reg;
                    end else begin
                        tbl_wdata = '0;
                        free_next = free_reg + 1'b1;
                    end
                end
                if (walk_stop) begin
                    chk_vld_next = 1'b0;
                end else if (walk_issue) begin
                    pos_next     = pos_reg + 1'b1;
                    kiss_next    = kiss_reg + 1'b1;
                    chk_pos_next = pos_reg;
                    chk_k_next   = kiss_reg;
                    chk_vld_next = 1'b1;
                end else begin
                    chk_vld_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_first_next  = BLK_W'(res_first_reg);
                    m_copy_next   = res_copy_reg;
                    m_csrc_next   = BLK_W'(res_csrc_reg);
                    m_cblk_next   = res_cblk_reg;
                    m_free_next   = free_reg;
                end
            end
            default: begin
                chk_vld_next = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= CNT_W'(ACTIVE_RESET);
            free_reg    <= CNT_W'(RESET_EFF);
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            free_reg    <= free_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        need_reg       <= need_next;
        size_zero_reg  <= size_zero_next;
        has_reg        <= has_next;
        blk_reg        <= blk_next;
        pos_reg        <= pos_next;
        chk_pos_reg    <= chk_pos_next;
        kiss_reg       <= kiss_next;
        chk_k_reg      <= chk_k_next;
        old_reg        <= old_next;
        keep_reg       <= keep_next;
        val_reg        <= val_next;
        run_reg        <= run_next;
        grow_reg       <= grow_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_copy_reg   <= res_copy_next;
        res_csrc_reg   <= res_csrc_next;
        res_cblk_reg   <= res_cblk_next;
        m_status_reg   <= m_status_next;
        m_first_reg    <= m_first_next;
        m_copy_reg     <= m_copy_next;
        m_csrc_reg     <= m_csrc_next;
        m_cblk_reg     <= m_cblk_next;
        m_free_reg     <= m_free_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_first_block = m_first_reg;
    assign m_copy_needed = m_copy_reg;
    assign m_copy_source = m_csrc_reg;
    assign m_copy_blocks = m_cblk_reg;
    assign m_free_blocks = m_free_reg;

    // The sequencer never writes the table while the sweep owns it.
    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !tbl_ctl.wr_en)
        else $error("table write during clearing sweep");

    // Free count stays within the active block count.
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= eff_cnt)
        else $error("free count above active block count");

    // Each fill cycle takes exactly one block off the free count.
    a_fill_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FILL |=> free_reg == $past(free_reg) - 1'b1)
        else $error("free count not decremented during fill");

    // A copy request comes only with a successful grow.
    a_copy_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_copy_needed |-> m_status == STAT_OK)
        else $error("copy request without ok status");

    // An accepted word always starts the head lookup.
    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_LOOK)
        else $error("accepted word did not start lookup");

endmodule
